// File: src/kwc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kwc_pkg: shared types and constants for the k-mer window counter
// Holds input kinds, register indexes, character codes and the base decoder.
// ---------------------------------------------------------------------------
package kwc_pkg;

	// Default sizing
	localparam int MAX_LEN_DEF    = 8;
	localparam int COUNT_BITS_DEF = 32;

	// Fixed field widths
	localparam int OUT_BITS   = 32;
	localparam int LEN_W      = 4;
	localparam int SYM_W      = 8;
	localparam int IDX_W      = 16;
	localparam int KIND_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;
	localparam int IN_DATA_W  = SYM_W + IDX_W;
	localparam int OUT_DATA_W = 3 * OUT_BITS;

	// Result queue depth, a power of two
	localparam int FIFO_DEPTH = 4;

	// Register reset values
	localparam logic [LEN_W-1:0] MOTIF_LEN_RST    = 4'd6;
	localparam logic             BOTH_STRANDS_RST = 1'b0;
	localparam logic             POSITIVE_SET_RST = 1'b1;

	// Nucleotide characters, upper case; lower case differs in bit 5
	localparam logic [SYM_W-1:0] CHAR_A    = 8'h41;
	localparam logic [SYM_W-1:0] CHAR_C    = 8'h43;
	localparam logic [SYM_W-1:0] CHAR_G    = 8'h47;
	localparam logic [SYM_W-1:0] CHAR_T    = 8'h54;
	localparam logic [SYM_W-1:0] CASE_BIT  = 8'h20;

	// 2-bit base codes; complement is 3 - code
	localparam logic [1:0] BASE_A = 2'd0;
	localparam logic [1:0] BASE_C = 2'd1;
	localparam logic [1:0] BASE_G = 2'd2;
	localparam logic [1:0] BASE_T = 2'd3;

	typedef enum logic [KIND_W-1:0] {
		KIND_CHAR  = 2'd0,
		KIND_BREAK = 2'd1,
		KIND_READ  = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MOTIF_LEN    = 2'd0,
		REG_BOTH_STRANDS = 2'd1,
		REG_POSITIVE_SET = 2'd2
	} reg_idx_t;

	typedef enum logic {
		OP_COUNT = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	typedef struct packed {
		logic       ok;
		logic [1:0] code;
	} base_t;

	// Map a character to its base code; ok is low for anything but acgt/ACGT
	function automatic base_t base_decode(input logic [SYM_W-1:0] c);
		base_t r;
		r.ok   = 1'b1;
		r.code = BASE_A;
		case (c) inside
			CHAR_A, CHAR_A | CASE_BIT: r.code = BASE_A;
			CHAR_C, CHAR_C | CASE_BIT: r.code = BASE_C;
			CHAR_G, CHAR_G | CASE_BIT: r.code = BASE_G;
			CHAR_T, CHAR_T | CASE_BIT: r.code = BASE_T;
			default:                   r.ok   = 1'b0;
		endcase
		return r;
	endfunction

endpackage

// File: src/kmer_window_counter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kmer_window_counter: canonical k-mer counter over a nucleotide stream
// Shifts bases into a window, counts each full window in a positive or
// negative table held in two single-port-per-side synchronous memories.
// ---------------------------------------------------------------------------
// A read request passes through stages 1 and 2 into the result queue for m_axis.
// Throughput: one request per cycle while credits remain; count updates are
// read-modify-write over two stages with last-write forwarding, so repeated k-mers never stall.
// A 4-entry result queue with credit accounting decouples m_axis back-pressure.
// Reset: after arst_n the tables are zeroed by a sweep over all 4^MAX_LEN entries
// (65536 by default), s_axis_tready low meanwhile; config writes always taken.
module kmer_window_counter
	import kwc_pkg::*;
#(
	parameter int MAX_LEN    = MAX_LEN_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input requests
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // symbol[7:0], entry_index[23:8]
	input  logic [KIND_W-1:0]     s_axis_tuser,  // kind[1:0]
	// results
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // pos_count[31:0], neg_count[63:32],
	                                             // total_motifs[95:64]
	// configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW    = 2 * MAX_LEN;
	localparam int DEPTH = 1 << AW;
	localparam int IW    = (AW > IDX_W) ? AW : IDX_W;
	localparam int VBW   = $clog2(MAX_LEN + 1);
	localparam int PW    = $clog2(FIFO_DEPTH);
	localparam int CW    = $clog2(FIFO_DEPTH + 1) + 1;
	localparam int SW    = LEN_W + 1;

	// Clamp a counter to the output width
	function automatic logic [OUT_BITS-1:0] sat_out(input logic [COUNT_BITS-1:0] v);
		logic [OUT_BITS-1:0] r;
		if ((v >> OUT_BITS) != '0) begin
			r = '1;
		end else begin
			r = OUT_BITS'(v);
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [LEN_W-1:0] motif_len_q;
	logic             both_q;
	logic             positive_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motif_len_q <= MOTIF_LEN_RST;
			both_q      <= BOTH_STRANDS_RST;
			positive_q  <= POSITIVE_SET_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MOTIF_LEN:    motif_len_q <= cfg_data;
				REG_BOTH_STRANDS: both_q      <= cfg_data[0];
				REG_POSITIVE_SET: positive_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Clamp the motif length into 2..MAX_LEN
	logic [LEN_W-1:0] eff_len;
	always_comb begin
		if (motif_len_q < LEN_W'(2)) begin
			eff_len = LEN_W'(2);
		end else if (motif_len_q > LEN_W'(MAX_LEN)) begin
			eff_len = LEN_W'(MAX_LEN);
		end else begin
			eff_len = motif_len_q;
		end
	end

	logic [AW-1:0] kmask;
	assign kmask = ~({AW{1'b1}} << {eff_len, 1'b0});

	// ------------------------------------------------------------------
	// Table clearing sweep after reset
	// ------------------------------------------------------------------
	logic          clearing_q;
	logic [AW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == {AW{1'b1}}) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 0: accept, window and total update
	// ------------------------------------------------------------------
	logic                  v_s1, v_s2;
	logic [CW-1:0]         fifo_cnt_q;
	logic [CW-1:0]         occupancy;
	logic                  in_acc;
	kind_t                 kind;
	logic [SYM_W-1:0]      symbol;
	logic [IDX_W-1:0]      entry_index;
	logic [IW-1:0]         idx_wide;
	base_t                 bd;
	logic [AW-1:0]         window_q;
	logic [VBW-1:0]        valid_q;
	logic [AW-1:0]         win_next;
	logic [VBW-1:0]        valid_next;
	logic                  count_hit;
	logic [COUNT_BITS-1:0] total_q;
	logic [COUNT_BITS:0]   total_sum;
	logic [AW-1:0]         code_s0;

	assign occupancy     = fifo_cnt_q + CW'(v_s1) + CW'(v_s2);
	assign s_axis_tready = !clearing_q && (occupancy < CW'(FIFO_DEPTH));
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	assign kind        = kind_t'(s_axis_tuser);
	assign symbol      = s_axis_tdata[SYM_W-1:0];
	assign entry_index = s_axis_tdata[SYM_W +: IDX_W];
	assign idx_wide    = IW'(entry_index);
	assign bd          = base_decode(symbol);
	assign win_next    = {window_q[AW-3:0], bd.code};
	assign valid_next  = (valid_q < VBW'(MAX_LEN)) ? valid_q + VBW'(1) : valid_q;
	assign count_hit   = in_acc && (kind == KIND_CHAR) && bd.ok
	                     && (LEN_W'(valid_next) >= eff_len);
	assign total_sum   = {1'b0, total_q} + (COUNT_BITS + 1)'(both_q ? 2 : 1);
	assign code_s0     = ((kind == KIND_READ) ? idx_wide[AW-1:0] : win_next) & kmask;

	// Shift the window on a base, drop it on any other character or a break
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			valid_q  <= '0;
		end else if (in_acc) begin
			case (kind)
				KIND_CHAR: begin
					if (bd.ok) begin
						window_q <= win_next;
						valid_q  <= valid_next;
					end else begin
						window_q <= '0;
						valid_q  <= '0;
					end
				end
				KIND_BREAK: begin
					window_q <= '0;
					valid_q  <= '0;
				end
				default: ;
			endcase
		end
	end

	// Saturating total of counted windows, two per window with both strands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (count_hit) begin
			total_q <= total_sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : total_sum[COUNT_BITS-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: canonical index, table read
	// ------------------------------------------------------------------
	op_t                   op_s1;
	logic [AW-1:0]         code_s1;
	logic [COUNT_BITS-1:0] total_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= count_hit || (in_acc && (kind == KIND_READ));
		end
	end

	always_ff @(posedge clk) begin
		op_s1    <= (kind == KIND_READ) ? OP_READ : OP_COUNT;
		code_s1  <= code_s0;
		total_s1 <= total_q;
	end

	logic [AW-1:0]    rev_s1;
	logic [AW-1:0]    rc_s1;
	logic [LEN_W-1:0] len_gap;
	logic [SW-1:0]    shamt;
	logic [AW-1:0]    canon_s1;
	logic             two_s1;

	// Reverse the base order across the full window width
	always_comb begin
		for (int i = 0; i < MAX_LEN; i++) begin
			rev_s1[2*(MAX_LEN-1-i) +: 2] = code_s1[2*i +: 2];
		end
	end

	// Complement, then drop the padding bases above the motif length
	assign len_gap  = LEN_W'(MAX_LEN) - eff_len;
	assign shamt    = {len_gap, 1'b0};
	assign rc_s1    = (~rev_s1) >> shamt;
	assign canon_s1 = (both_q && (rc_s1 < code_s1)) ? rc_s1 : code_s1;
	assign two_s1   = both_q && (rc_s1 == code_s1);

	// ------------------------------------------------------------------
	// Stage 2: modify with forwarding, write back, emit reads
	// ------------------------------------------------------------------
	op_t                   op_s2;
	logic [AW-1:0]         addr_s2;
	logic                  two_s2;
	logic [COUNT_BITS-1:0] total_s2;
	logic [COUNT_BITS-1:0] pos_rd_s2;
	logic [COUNT_BITS-1:0] neg_rd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s2    <= op_s1;
		addr_s2  <= canon_s1;
		two_s2   <= two_s1;
		total_s2 <= total_s1;
	end

	// Last write, forwarded to the entry read in the same cycle
	logic                  lw_pos_q;
	logic                  lw_neg_q;
	logic [AW-1:0]         lw_addr_q;
	logic [COUNT_BITS-1:0] lw_data_q;
	logic [COUNT_BITS-1:0] pos_cur;
	logic [COUNT_BITS-1:0] neg_cur;
	logic [COUNT_BITS-1:0] target;
	logic [COUNT_BITS:0]   upd_sum;
	logic [COUNT_BITS-1:0] upd_val;
	logic                  upd_s2;
	logic                  wr_pos;
	logic                  wr_neg;
	logic [AW-1:0]         wr_addr;
	logic [COUNT_BITS-1:0] wr_data;

	assign pos_cur = (lw_pos_q && (lw_addr_q == addr_s2)) ? lw_data_q : pos_rd_s2;
	assign neg_cur = (lw_neg_q && (lw_addr_q == addr_s2)) ? lw_data_q : neg_rd_s2;
	assign target  = positive_q ? pos_cur : neg_cur;
	assign upd_sum = {1'b0, target} + (COUNT_BITS + 1)'(two_s2 ? 2 : 1);
	assign upd_val = upd_sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : upd_sum[COUNT_BITS-1:0];
	assign upd_s2  = v_s2 && (op_s2 == OP_COUNT);

	// Sweep zeros during clearing, else write back the updated count
	assign wr_pos  = clearing_q || (upd_s2 && positive_q);
	assign wr_neg  = clearing_q || (upd_s2 && !positive_q);
	assign wr_addr = clearing_q ? clr_addr_q : addr_s2;
	assign wr_data = clearing_q ? '0 : upd_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_pos_q <= 1'b0;
			lw_neg_q <= 1'b0;
		end else begin
			lw_pos_q <= upd_s2 && positive_q;
			lw_neg_q <= upd_s2 && !positive_q;
		end
	end

	always_ff @(posedge clk) begin
		lw_addr_q <= addr_s2;
		lw_data_q <= upd_val;
	end

	// Count tables
	logic [COUNT_BITS-1:0] pos_mem [DEPTH];
	logic [COUNT_BITS-1:0] neg_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_pos) begin
			pos_mem[wr_addr] <= wr_data;
		end
		if (v_s1) begin
			pos_rd_s2 <= pos_mem[canon_s1];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_neg) begin
			neg_mem[wr_addr] <= wr_data;
		end
		if (v_s1) begin
			neg_rd_s2 <= neg_mem[canon_s1];
		end
	end

	// ------------------------------------------------------------------
	// Result queue
	// ------------------------------------------------------------------
	logic [OUT_DATA_W-1:0] fifo_q [FIFO_DEPTH];
	logic [PW-1:0]         wr_ptr_q;
	logic [PW-1:0]         rd_ptr_q;
	logic                  push;
	logic                  pop;

	assign push          = v_s2 && (op_s2 == OP_READ);
	assign m_axis_tvalid = (fifo_cnt_q != '0);
	assign pop           = m_axis_tvalid && m_axis_tready;
	assign m_axis_tdata  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= {sat_out(total_s2), sat_out(neg_cur), sat_out(pos_cur)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			fifo_cnt_q <= fifo_cnt_q + CW'(push) - CW'(pop);
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occupancy <= CW'(FIFO_DEPTH))
		else $error("result credits exceeded queue depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (fifo_cnt_q < CW'(FIFO_DEPTH)) || pop)
		else $error("result pushed into a full queue");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !v_s1 && !v_s2)
		else $error("request in flight during table clearing");

	a_read_emits: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> m_axis_tvalid)
		else $error("read result not presented after push");

endmodule
